// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FDSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdsd assertion failed");

// next-cycle implication, checked outside reset
`define FDSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdsd assertion failed");

`endif

// ===== hdl/fdsd_pkg.sv =====
// Package: request codes, framing constants and segment table for the display framer
`default_nettype none

package fdsd_pkg;

    typedef enum logic [1:0] {
        OP_NUMBER = 2'd0,
        OP_TIME   = 2'd1,
        OP_BLANK  = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        logic stop;
        logic last;
    } t_frame;

    localparam logic [7:0] CMD_DATA      = 8'h44;
    localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY   = 8'h88;
    localparam logic [7:0] SEG_COLON     = 8'h80;
    localparam logic [6:0] MAX_TWO_DIGIT = 7'd99;
    localparam logic [2:0] BRIGHT_RESET  = 3'd2;
    localparam logic       REG_BRIGHTNESS = 1'b0;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/four_digit_segment_display_framer.sv =====
// Top level: display request framer with APB brightness register
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  request  | i_valid / o_ready  | i_op, i_number, i_hours, i_minutes, i_colon_on
//  bytes    | o_valid / i_ready  | o_wire_byte, o_frame_start, o_frame_stop, o_last
//  config   | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
//  One byte per cycle leaves the output register while i_ready is high; a request is
//  2*DIGIT_COUNT+2 bytes, set by the byte sequencer. A number is converted by repeated
//  divide-by-ten in the front end, overlapped with the previous request's bytes via a
//  two-entry queue. Reset is synchronous, active low; brightness resets to 2.
//  Output stalls hold the byte; input stalls while the front end holds a request.
`default_nettype none

module four_digit_segment_display_framer import fdsd_pkg::*; #(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_number,
    input  wire logic [6:0]  i_hours,
    input  wire logic [6:0]  i_minutes,
    input  wire logic        i_colon_on,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_wire_byte,
    output logic             o_frame_start,
    output logic             o_frame_stop,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "assert_macros.svh"

    logic [2:0]                    r_brightness;
    logic                          w_push_valid;
    logic                          w_push_ready;
    logic [DIGIT_COUNT-1:0][7:0]   w_push_segs;
    logic                          w_pop_valid;
    logic                          w_pop_ready;
    logic [DIGIT_COUNT-1:0][7:0]   w_pop_segs;
    t_frame                        w_flags;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BRIGHTNESS) ? {29'd0, r_brightness} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BRIGHTNESS) begin
            r_brightness <= pwdata[2:0];
        end
    end

    fdsd_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_number     (i_number),
        .i_hours      (i_hours),
        .i_minutes    (i_minutes),
        .i_colon_on   (i_colon_on),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_segs  (w_push_segs)
    );

    fdsd_queue #(
        .WIDTH (DIGIT_COUNT * 8)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_push_valid),
        .o_in_ready  (w_push_ready),
        .i_in_data   (w_push_segs),
        .o_out_valid (w_pop_valid),
        .i_out_ready (w_pop_ready),
        .o_out_data  (w_pop_segs)
    );

    fdsd_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_pop_valid),
        .o_pop_ready  (w_pop_ready),
        .i_pop_segs   (w_pop_segs),
        .i_brightness (r_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte       (o_wire_byte),
        .o_flags      (w_flags)
    );

    assign o_frame_start = w_flags.start;
    assign o_frame_stop  = w_flags.stop;
    assign o_last        = w_flags.last;

    `FDSD_ASSERT_IMPL(a_last_is_display_cmd, i_clk, i_rst_n, o_valid && o_last,
        o_frame_start && o_frame_stop && o_wire_byte[7:3] == CMD_DISPLAY[7:3])
    `FDSD_ASSERT_NEXT(a_addr_then_segment, i_clk, i_rst_n,
        o_valid && i_ready && o_frame_start && !o_frame_stop,
        o_valid && !o_frame_start && o_frame_stop)
    `FDSD_ASSERT_NEXT(a_front_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

`default_nettype wire

// ===== hdl/fdsd_front.sv =====
// Front end: accepts requests and builds the per-digit segment codes
`default_nettype none

module fdsd_front import fdsd_pkg::*; #(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_op,
    input  wire logic [15:0]                 i_number,
    input  wire logic [6:0]                  i_hours,
    input  wire logic [6:0]                  i_minutes,
    input  wire logic                        i_colon_on,
    output logic                             o_push_valid,
    input  wire logic                        i_push_ready,
    output logic [DIGIT_COUNT-1:0][7:0]      o_push_segs
);

    localparam int CW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [15:0] DIV10_MUL_WIDE  = 16'hCCCD;
    localparam logic [7:0]  DIV10_MUL_SMALL = 8'd205;

    logic                          r_busy;
    logic                          r_conv;
    logic [CW-1:0]                 r_cnt;
    logic [15:0]                   r_val;
    logic [DIGIT_COUNT-1:0][7:0]   r_segs;

    logic                          w_accept;
    logic [31:0]                   w_prod;
    logic [12:0]                   w_quot;
    logic [15:0]                   w_quot10;
    logic [15:0]                   w_rem;
    logic [6:0]                    w_hrs;
    logic [6:0]                    w_mins;
    logic [14:0]                   w_hprod;
    logic [14:0]                   w_mprod;
    logic [3:0]                    w_htens;
    logic [3:0]                    w_mtens;
    logic [6:0]                    w_hunits;
    logic [6:0]                    w_munits;
    logic [3:0][7:0]               w_tdig;
    logic [DIGIT_COUNT-1:0][7:0]   w_time_segs;

    assign o_ready      = !r_busy;
    assign w_accept     = i_valid && o_ready;
    assign o_push_valid = r_busy && !r_conv;
    assign o_push_segs  = r_segs;

    // one decimal digit per cycle: reciprocal multiply, then remainder
    assign w_prod   = {16'd0, r_val} * {16'd0, DIV10_MUL_WIDE};
    assign w_quot   = w_prod[31:19];
    assign w_quot10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_rem    = r_val - w_quot10;

    always_comb begin
        w_hrs    = (i_hours > MAX_TWO_DIGIT) ? MAX_TWO_DIGIT : i_hours;
        w_mins   = (i_minutes > MAX_TWO_DIGIT) ? MAX_TWO_DIGIT : i_minutes;
        w_hprod  = {8'd0, w_hrs} * {7'd0, DIV10_MUL_SMALL};
        w_mprod  = {8'd0, w_mins} * {7'd0, DIV10_MUL_SMALL};
        w_htens  = w_hprod[14:11];
        w_mtens  = w_mprod[14:11];
        w_hunits = w_hrs - ({3'b000, w_htens} * 7'd10);
        w_munits = w_mins - ({3'b000, w_mtens} * 7'd10);
        w_tdig[0] = seg_code(w_htens);
        w_tdig[1] = seg_code(w_hunits[3:0]) | (i_colon_on ? SEG_COLON : 8'h00);
        w_tdig[2] = seg_code(w_mtens);
        w_tdig[3] = seg_code(w_munits[3:0]);
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            w_time_segs[i] = (i < 4) ? w_tdig[i % 4] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_conv <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                case (t_op'(i_op))
                    OP_NUMBER: begin
                        r_conv <= 1'b1;
                        r_cnt  <= CW'(DIGIT_COUNT - 1);
                        r_val  <= i_number;
                    end
                    OP_TIME: begin
                        r_conv <= 1'b0;
                        r_segs <= w_time_segs;
                    end
                    default: begin
                        r_conv <= 1'b0;
                        r_segs <= '0;
                    end
                endcase
            end else if (r_conv) begin
                r_segs[r_cnt] <= seg_code(w_rem[3:0]);
                r_val         <= {3'b000, w_quot};
                if (r_cnt == '0) begin
                    r_conv <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (o_push_valid && i_push_ready) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fdsd_queue.sv =====
// Two-entry queue between the front end and the byte sequencer
`default_nettype none

module fdsd_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [WIDTH-1:0] i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [WIDTH-1:0]      o_out_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_mem[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fdsd_back.sv =====
// Back end: walks one request through its framed byte sequence
`default_nettype none

module fdsd_back import fdsd_pkg::*; #(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_pop_valid,
    output logic                             o_pop_ready,
    input  wire logic [DIGIT_COUNT-1:0][7:0] i_pop_segs,
    input  wire logic [2:0]                  i_brightness,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [7:0]                       o_byte,
    output t_frame                           o_flags
);

    localparam int CW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int KW = $clog2(2 * DIGIT_COUNT + 2);
    localparam logic [KW-1:0] K_LAST = KW'(2 * DIGIT_COUNT + 1);

    logic                          r_cur_valid;
    logic [KW-1:0]                 r_k;
    logic [DIGIT_COUNT-1:0][7:0]   r_segs;
    logic                          r_out_valid;
    logic [7:0]                    r_byte;
    t_frame                        r_flags;

    logic                          w_advance;
    logic                          w_pop;
    logic [KW-1:0]                 w_km1;
    logic [CW-1:0]                 w_di;
    logic [7:0]                    w_byte;
    t_frame                        w_flags;

    assign o_valid     = r_out_valid;
    assign o_byte      = r_byte;
    assign o_flags     = r_flags;
    assign w_advance   = !r_out_valid || i_ready;
    assign o_pop_ready = !r_cur_valid || (w_advance && r_k == K_LAST);
    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_km1       = r_k - 1'b1;
    assign w_di        = w_km1[CW:1];

    always_comb begin
        if (r_k == '0) begin
            w_byte  = CMD_DATA;
            w_flags = '{start: 1'b1, stop: 1'b1, last: 1'b0};
        end else if (r_k == K_LAST) begin
            w_byte  = CMD_DISPLAY | {5'b00000, i_brightness};
            w_flags = '{start: 1'b1, stop: 1'b1, last: 1'b1};
        end else if (r_k[0]) begin
            w_byte  = CMD_ADDR_BASE + 8'(w_di);
            w_flags = '{start: 1'b1, stop: 1'b0, last: 1'b0};
        end else begin
            w_byte  = r_segs[w_di];
            w_flags = '{start: 1'b0, stop: 1'b1, last: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_cur_valid;
                if (r_cur_valid) begin
                    r_byte  <= w_byte;
                    r_flags <= w_flags;
                end
            end
            if (w_pop) begin
                r_cur_valid <= 1'b1;
                r_segs      <= i_pop_segs;
                r_k         <= '0;
            end else if (w_advance && r_cur_valid) begin
                if (r_k == K_LAST) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/fdsd_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for the display framer: predicts each request's framed bytes and compares the output
`default_nettype none

module fdsd_frame_checker import fdsd_pkg::*; #(
    parameter int         DIGIT_COUNT     = 4,
    parameter logic [2:0] BRIGHTNESS_ADDR = 3'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_number,
    input  wire logic [6:0]  i_hours,
    input  wire logic [6:0]  i_minutes,
    input  wire logic        i_colon_on,
    input  wire logic        i_byte_valid,
    input  wire logic        i_byte_ready,
    input  wire logic [7:0]  i_wire_byte,
    input  wire logic        i_frame_start,
    input  wire logic        i_frame_stop,
    input  wire logic        i_last,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_requests,
    output int               o_bytes
);

    typedef struct packed {
        logic [7:0] wire_byte;
        t_frame     frame;
    } t_framed_byte;

    localparam logic [79:0] DIGIT_GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                            8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

    t_framed_byte frame_queue[$];
    logic [2:0]   brightness_q;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_requests   = 0;
        o_bytes      = 0;
        brightness_q = BRIGHT_RESET;
    end

    function automatic logic [7:0] glyph(input int digit);
        return DIGIT_GLYPHS[digit*8 +: 8];
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic start,
                                      input logic stop, input logic last);
        t_framed_byte item;
        item.wire_byte   = b;
        item.frame.start = start;
        item.frame.stop  = stop;
        item.frame.last  = last;
        frame_queue.push_back(item);
    endfunction

    function automatic void predict_frames(input logic [1:0] op, input logic [15:0] number,
                                           input logic [6:0] hours, input logic [6:0] minutes,
                                           input logic colon_on);
        logic [7:0] digits [DIGIT_COUNT];
        logic [7:0] clock_digits [4];
        int         value;
        int         hrs;
        int         mins;
        for (int i = 0; i < DIGIT_COUNT; i++) digits[i] = 8'h00;
        case (t_op'(op))
            OP_NUMBER: begin
                value = number;
                for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
                    digits[i] = glyph(value % 10);
                    value = value / 10;
                end
            end
            OP_TIME: begin
                hrs  = (hours > MAX_TWO_DIGIT) ? MAX_TWO_DIGIT : hours;
                mins = (minutes > MAX_TWO_DIGIT) ? MAX_TWO_DIGIT : minutes;
                clock_digits[0] = glyph(hrs / 10);
                clock_digits[1] = glyph(hrs % 10);
                clock_digits[2] = glyph(mins / 10);
                clock_digits[3] = glyph(mins % 10);
                if (colon_on) clock_digits[1] = clock_digits[1] | SEG_COLON;
                for (int i = 0; i < DIGIT_COUNT && i < 4; i++) digits[i] = clock_digits[i];
            end
            default: begin
            end
        endcase
        push_byte(CMD_DATA, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            push_byte(CMD_ADDR_BASE + 8'(i), 1'b1, 1'b0, 1'b0);
            push_byte(digits[i], 1'b0, 1'b1, 1'b0);
        end
        push_byte(CMD_DISPLAY | {5'd0, brightness_q}, 1'b1, 1'b1, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_framed_byte want;
        if (!i_rst_n) begin
            brightness_q <= BRIGHT_RESET;
            frame_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BRIGHTNESS_ADDR)
                brightness_q <= i_pwdata[2:0];
            if (i_req_valid && i_req_ready) begin
                predict_frames(i_op, i_number, i_hours, i_minutes, i_colon_on);
                o_requests++;
            end
            if (i_byte_valid && i_byte_ready) begin
                o_bytes++;
                if (frame_queue.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected byte %02h start %0b stop %0b last %0b",
                                 i_wire_byte, i_frame_start, i_frame_stop, i_last);
                end else begin
                    want = frame_queue.pop_front();
                    if (want.wire_byte !== i_wire_byte || want.frame.start !== i_frame_start ||
                        want.frame.stop !== i_frame_stop || want.frame.last !== i_last) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("byte %0d: expected %02h/%0b%0b%0b, got %02h/%0b%0b%0b",
                                     o_bytes, want.wire_byte, want.frame.start,
                                     want.frame.stop, want.frame.last, i_wire_byte,
                                     i_frame_start, i_frame_stop, i_last);
                    end
                end
            end
        end
        o_pending = frame_queue.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_four_digit_segment_display_framer.sv =====
`timescale 1ns / 100ps
// Testbench top: drives display requests and brightness writes, and reports the verdict
`default_nettype none

module tb_four_digit_segment_display_framer import fdsd_pkg::*; ();

    localparam int         DIGITS          = 4;
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [2:0] BRIGHTNESS_ADDR = 3'(4 * REG_BRIGHTNESS);
    localparam int         SETTLE_CYCLES   = 30;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         ITEMS_PER_PHASE = 36;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [15:0] i_number;
    logic [6:0]  i_hours;
    logic [6:0]  i_minutes;
    logic        i_colon_on;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_wire_byte;
    logic        o_frame_start;
    logic        o_frame_stop;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending_bytes;
    int requests_seen;
    int bytes_seen;
    int idle_pct;
    int stall_pct;
    int hold_requests;

    four_digit_segment_display_framer #(.DIGIT_COUNT(DIGITS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_number(i_number), .i_hours(i_hours), .i_minutes(i_minutes),
        .i_colon_on(i_colon_on),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_wire_byte(o_wire_byte), .o_frame_start(o_frame_start),
        .o_frame_stop(o_frame_stop), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fdsd_frame_checker #(.DIGIT_COUNT(DIGITS), .BRIGHTNESS_ADDR(BRIGHTNESS_ADDR)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_valid), .i_req_ready(o_ready),
        .i_op(i_op), .i_number(i_number), .i_hours(i_hours), .i_minutes(i_minutes),
        .i_colon_on(i_colon_on),
        .i_byte_valid(o_valid), .i_byte_ready(i_ready),
        .i_wire_byte(o_wire_byte), .i_frame_start(o_frame_start),
        .i_frame_stop(o_frame_stop), .i_last(o_last),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_mismatches(mismatches), .o_pending(pending_bytes),
        .o_requests(requests_seen), .o_bytes(bytes_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("four_digit_segment_display_framer regression: fail");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [15:0] number,
                                input logic [6:0] hours, input logic [6:0] minutes,
                                input logic colon_on);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_number   <= number;
        i_hours    <= hours;
        i_minutes  <= minutes;
        i_colon_on <= colon_on;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        logic [6:0] hours;
        logic [6:0] minutes;
        hours   = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(99));
        minutes = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 100)) : 7'($urandom_range(99));
        send_request(2'($urandom_range(3)), 16'($urandom_range(65535)), hours, minutes,
                     1'($urandom_range(1)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_bytes != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_brightness(input logic [2:0] level);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BRIGHTNESS_ADDR;
        pwdata  <= {29'd0, level};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_BLANK;
        i_number      = 16'd0;
        i_hours       = 7'd0;
        i_minutes     = 7'd0;
        i_colon_on    = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(OP_NUMBER, 16'd0, 7'd0, 7'd0, 1'b0);
        send_request(OP_NUMBER, 16'd9999, 7'd0, 7'd0, 1'b0);
        send_request(OP_NUMBER, 16'd10000, 7'd0, 7'd0, 1'b0);
        send_request(OP_NUMBER, 16'd65535, 7'd127, 7'd127, 1'b1);
        send_request(OP_NUMBER, 16'd1234, 7'd0, 7'd0, 1'b0);
        send_request(OP_NUMBER, 16'd5678, 7'd0, 7'd0, 1'b1);
        send_request(OP_NUMBER, 16'd8888, 7'd0, 7'd0, 1'b0);
        send_request(OP_TIME, 16'd0, 7'd0, 7'd0, 1'b0);
        send_request(OP_TIME, 16'd0, 7'd23, 7'd59, 1'b1);
        send_request(OP_TIME, 16'd0, 7'd99, 7'd99, 1'b1);
        send_request(OP_TIME, 16'd0, 7'd100, 7'd100, 1'b0);
        send_request(OP_TIME, 16'hFFFF, 7'd127, 7'd127, 1'b1);
        send_request(OP_TIME, 16'd0, 7'd7, 7'd127, 1'b1);
        send_request(OP_TIME, 16'd0, 7'd12, 7'd34, 1'b0);
        send_request(OP_BLANK, 16'hFFFF, 7'd127, 7'd127, 1'b1);
        send_request(OP_BLANK, 16'd0, 7'd0, 7'd0, 1'b0);
        send_request(OP_UNUSED, 16'd4321, 7'd12, 7'd34, 1'b1);
        send_request(OP_UNUSED, 16'd0, 7'd0, 7'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  write_brightness(3'd7); end
                1: begin idle_pct = 85; stall_pct = 0;  write_brightness(3'd0); end
                2: begin idle_pct = 0;  stall_pct = 85; write_brightness(3'($urandom_range(7))); end
                default: begin
                    idle_pct  = 14;
                    stall_pct = 14;
                    write_brightness(3'($urandom_range(7)));
                end
            endcase
            // stall the output long enough to back up the request queue
            if (phase == 0) hold_requests++;
            repeat (ITEMS_PER_PHASE) send_random_request();
            drain();
        end

        $display("covered %0d requests and %0d framed bytes over four flow-control phases",
                 requests_seen, bytes_seen);
        $display("with brightness at reset, both extremes and random levels");
        if (mismatches == 0) begin
            $display("four_digit_segment_display_framer regression: pass");
        end else begin
            $display("four_digit_segment_display_framer regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
